// File: design/fccw_pkg.sv
// Shared types and constants for the FAT12 cluster chain walker.
package fccw_pkg;

  // Table and sector geometry
  localparam int TABLE_BYTES  = 6144;
  localparam int TABLE_AW     = $clog2(TABLE_BYTES);
  localparam int SECTOR_BYTES = 512;

  // Field widths
  localparam int CMD_W     = 2;
  localparam int INDEX_W   = 13;
  localparam int BYTE_W    = 8;
  localparam int CLUSTER_W = 12;
  localparam int LENGTH_W  = 32;
  localparam int SECTOR_W  = 17;
  localparam int COUNT_W   = 10;
  localparam int DSS_W     = 16;
  localparam int OFF_W     = CLUSTER_W + 2;

  // Constants of the chain
  localparam logic [CLUSTER_W-1:0] END_MARK  = 12'hFF8;
  localparam logic [DSS_W-1:0]     DSS_RESET = 16'd33;

  // Command queue depth
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Command codes on the input channel
  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd2;

  // Decoded operation carried through the queue
  typedef enum logic [1:0] {
    OP_LOAD,
    OP_START,
    OP_ADVANCE
  } fccw_op_e;

  typedef struct packed {
    fccw_op_e              op;
    logic [INDEX_W-1:0]    pos;   // table index or first cluster
    logic [LENGTH_W-1:0]   val;   // table byte or file length
  } fccw_op_t;

  typedef struct packed {
    logic [SECTOR_W-1:0] sector;
    logic [COUNT_W-1:0]  byte_count;
    logic                last;
    logic                chain_error;
  } fccw_result_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD_LO,
    ST_RD_HI,
    ST_RESOLVE
  } fccw_state_e;

endpackage

// File: design/fccw_if.sv
// Channel interfaces for the command input and the result output.
interface fccw_in_if import fccw_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     command;
  logic [INDEX_W-1:0]   table_index;
  logic [BYTE_W-1:0]    table_byte;
  logic [CLUSTER_W-1:0] first_cluster;
  logic [LENGTH_W-1:0]  file_length;

  modport source (
    output valid, command, table_index, table_byte, first_cluster, file_length,
    input  ready
  );
  modport sink (
    input  valid, command, table_index, table_byte, first_cluster, file_length,
    output ready
  );
endinterface

interface fccw_out_if import fccw_pkg::*;;
  logic                valid;
  logic                ready;
  logic [SECTOR_W-1:0] sector;
  logic [COUNT_W-1:0]  byte_count;
  logic                last;
  logic                chain_error;

  modport source (
    output valid, sector, byte_count, last, chain_error,
    input  ready
  );
  modport sink (
    input  valid, sector, byte_count, last, chain_error,
    output ready
  );
endinterface

// File: design/fccw_front.sv
// Front end: accepts command words, decodes them and drops ones with no effect.
module fccw_front import fccw_pkg::*; (
  fccw_in_if.sink   in_ch,
  output logic      push_valid,
  input  logic      push_ready,
  output fccw_op_t  push_data
);

  logic keep;

  // Decode the command and pack its operands
  always_comb begin
    keep           = 1'b0;
    push_data.op   = OP_LOAD;
    push_data.pos  = in_ch.table_index;
    push_data.val  = LENGTH_W'(in_ch.table_byte);
    case (in_ch.command)
      CMD_LOAD: begin
        // drop loads that fall outside the table
        keep = (32'(in_ch.table_index) < TABLE_BYTES);
      end
      CMD_START: begin
        keep          = 1'b1;
        push_data.op  = OP_START;
        push_data.pos = INDEX_W'(in_ch.first_cluster);
        push_data.val = in_ch.file_length;
      end
      CMD_ADVANCE: begin
        keep         = 1'b1;
        push_data.op = OP_ADVANCE;
      end
      default: keep = 1'b0;
    endcase
  end

  // Take a word only when the queue has room, so none is lost
  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid && keep;

endmodule

// File: design/fccw_queue.sv
// Short FIFO of decoded operations between front and back end.
module fccw_queue import fccw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  fccw_op_t push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output fccw_op_t pop_data
);

  localparam logic [QUEUE_AW-1:0] LAST_SLOT = QUEUE_AW'(QUEUE_DEPTH - 1);

  fccw_op_t            slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]   count_r, count_nxt;
  logic                do_push, do_pop;

  assign push_ready = (count_r != (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: design/fccw_back.sv
// Back end: allocation table memory, chain state and result register.
module fccw_back import fccw_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [DSS_W-1:0] data_start_sector,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  fccw_op_t         pop_data,
  output logic             out_valid,
  input  logic             out_ready,
  output fccw_result_t     out_data
);

  fccw_state_e state_r, state_nxt;

  logic [CLUSTER_W-1:0] cluster_r, cluster_nxt;
  logic [CLUSTER_W-1:0] next_cluster_r, next_cluster_nxt;
  logic [LENGTH_W-1:0]  bytes_rem_r, bytes_rem_nxt;
  logic                 chain_active_r, chain_active_nxt;
  logic [BYTE_W-1:0]    lo_r, lo_nxt;
  logic                 out_valid_r, out_valid_nxt;
  fccw_result_t         out_data_r, out_data_nxt;

  logic [BYTE_W-1:0]    table_mem [TABLE_BYTES];
  logic [BYTE_W-1:0]    rd_data_r;
  logic                 rd_ok_r;
  logic [OFF_W-1:0]     rd_addr;
  logic [OFF_W-1:0]     off;
  logic [BYTE_W-1:0]    rd_byte;
  logic                 mem_we;
  logic                 out_free;
  logic [CLUSTER_W-1:0] entry;
  logic                 end_of_chain;
  logic [COUNT_W-1:0]   count;

  // Byte offset of the packed entry: cluster * 1.5
  assign off     = OFF_W'(cluster_r) + OFF_W'(cluster_r >> 1);
  assign rd_byte = rd_ok_r ? rd_data_r : '0;

  // Unpack the 12-bit entry from the low and high bytes
  always_comb begin
    if (cluster_r[0]) begin
      entry = {rd_byte, lo_r[7:4]};
    end else begin
      entry = {rd_byte[3:0], lo_r};
    end
    end_of_chain = (entry >= END_MARK);
    count = (bytes_rem_r >= LENGTH_W'(SECTOR_BYTES)) ? COUNT_W'(SECTOR_BYTES)
                                                    : bytes_rem_r[COUNT_W-1:0];
  end

  assign out_free = !out_valid_r || out_ready;

  // Sequence one operation at a time
  always_comb begin
    state_nxt        = state_r;
    cluster_nxt      = cluster_r;
    next_cluster_nxt = next_cluster_r;
    bytes_rem_nxt    = bytes_rem_r;
    chain_active_nxt = chain_active_r;
    lo_nxt           = lo_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_data_nxt     = out_data_r;
    pop_ready        = 1'b0;
    mem_we           = 1'b0;
    rd_addr          = off;
    case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          case (pop_data.op)
            OP_LOAD: begin
              pop_ready = 1'b1;
              mem_we    = 1'b1;
            end
            OP_START: begin
              if (out_free) begin
                pop_ready     = 1'b1;
                cluster_nxt   = pop_data.pos[CLUSTER_W-1:0];
                bytes_rem_nxt = pop_data.val;
                state_nxt     = ST_RD_LO;
              end
            end
            OP_ADVANCE: begin
              if (out_free) begin
                pop_ready = 1'b1;
                if (chain_active_r) begin
                  cluster_nxt = next_cluster_r;
                  state_nxt   = ST_RD_LO;
                end else begin
                  // no chain open: flag it, leave the state alone
                  out_valid_nxt            = 1'b1;
                  out_data_nxt.sector      = '0;
                  out_data_nxt.byte_count  = '0;
                  out_data_nxt.last        = 1'b0;
                  out_data_nxt.chain_error = 1'b1;
                end
              end
            end
            default: pop_ready = 1'b1;
          endcase
        end
      end
      ST_RD_LO: begin
        rd_addr   = off;
        state_nxt = ST_RD_HI;
      end
      ST_RD_HI: begin
        rd_addr   = off + 1'b1;
        lo_nxt    = rd_byte;
        state_nxt = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        bytes_rem_nxt    = bytes_rem_r - LENGTH_W'(count);
        chain_active_nxt = !end_of_chain;
        if (!end_of_chain) begin
          next_cluster_nxt = entry;
        end
        out_valid_nxt            = 1'b1;
        out_data_nxt.sector      = SECTOR_W'(data_start_sector) + SECTOR_W'(cluster_r)
                                   - SECTOR_W'(2);
        out_data_nxt.byte_count  = count;
        out_data_nxt.last        = end_of_chain;
        out_data_nxt.chain_error = 1'b0;
        state_nxt                = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control and chain state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      next_cluster_r <= '0;
      bytes_rem_r    <= '0;
      chain_active_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      next_cluster_r <= next_cluster_nxt;
      bytes_rem_r    <= bytes_rem_nxt;
      chain_active_r <= chain_active_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cluster_r  <= cluster_nxt;
    lo_r       <= lo_nxt;
    out_data_r <= out_data_nxt;
  end

  // Allocation table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[pop_data.pos[TABLE_AW-1:0]] <= pop_data.val[BYTE_W-1:0];
    end
    rd_data_r <= table_mem[rd_addr[TABLE_AW-1:0]];
    rd_ok_r   <= (32'(rd_addr) < TABLE_BYTES);
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: design/fat12_cluster_chain_walker.sv
// Top level of the FAT12 cluster chain walker.
// Usage:
//   in_ch carries command words: load table byte, start chain, advance.
//   A load writes one allocation table byte and gives no result; a command
//   value of 3 and a load past the table end are dropped without a result.
//   Start and advance each give one word on out_ch: data sector, byte count
//   (up to 512), last flag, and chain_error for an advance with no chain.
//   cfg_we/cfg_wdata write data_start_sector (reset 33); write only when idle.
// Timing:
//   A decoded command waits in a two-word queue. A load is popped and written
//   into the table in the same cycle. A start or active advance passes the
//   back end in order: pop, read the low and high table byte, then unpack
//   the entry into the result register, and only then pops the next word.
//   An advance with no active chain has its result valid in the cycle after
//   it is popped. Rate: one load per cycle while the back end is idle.
// Reset clears the chain state, the queue and out_ch valid; the table
// contents are undefined until loaded. When out_ch stalls the result holds,
// the back end stops before its next result and the queue fills, then in_ch
// drops ready.
module fat12_cluster_chain_walker import fccw_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  fccw_in_if.sink          in_ch,
  fccw_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [DSS_W-1:0] cfg_wdata
);

  logic [DSS_W-1:0] dss_r;
  logic             push_valid, push_ready;
  fccw_op_t         push_data;
  logic             pop_valid, pop_ready;
  fccw_op_t         pop_data;
  fccw_result_t     result;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dss_r <= DSS_RESET;
    end else if (cfg_we) begin
      dss_r <= cfg_wdata;
    end
  end

  fccw_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  fccw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  fccw_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .data_start_sector (dss_r),
    .pop_valid         (pop_valid),
    .pop_ready         (pop_ready),
    .pop_data          (pop_data),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_data          (result)
  );

  // Drive the result channel
  assign out_ch.sector      = result.sector;
  assign out_ch.byte_count  = result.byte_count;
  assign out_ch.last        = result.last;
  assign out_ch.chain_error = result.chain_error;

endmodule
